/* rtl/base64_stream_encoder_core_macros.svh */
// Assertion macros shared by the base64 stream encoder RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef BASE64_STREAM_ENCODER_CORE_MACROS_SVH
`define BASE64_STREAM_ENCODER_CORE_MACROS_SVH

`define B64E_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define B64E_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/b64e_pkg.sv */
// Types, constants and the alphabet lookup for the base64 stream encoder.
// No dependencies.
package b64e_pkg;

  localparam int MAX_CHARS = 4;
  localparam int CHAR_W = 7;
  localparam int CHAR_IDX_W = 2;

  localparam logic [2:0] RES_NONE = 3'd0;
  localparam logic [2:0] RES_TWO = 3'd2;
  localparam logic [2:0] RES_FOUR = 3'd4;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;

  typedef struct packed {
    logic [MAX_CHARS-1:0][CHAR_W-1:0] codes;
    logic [CHAR_IDX_W-1:0] last_idx;
    logic last;
  } job_t;

  function automatic logic [CHAR_W-1:0] encode_sextet(input logic [5:0] v);
    logic [CHAR_W-1:0] code;
    case (v) inside
      [6'd0 : 6'd25]: code = 7'd65 + {1'b0, v};
      [6'd26 : 6'd51]: code = 7'd71 + {1'b0, v};
      [6'd52 : 6'd61]: code = {1'b0, v} - 7'd4;
      6'd62: code = 7'd43;
      default: code = 7'd47;
    endcase
    return code;
  endfunction

endpackage

/* rtl/b64e_front.sv */
// Front end: accepts bytes, tracks the leftover bits and builds one
// character job per byte. Depends on b64e_pkg.
module b64e_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  output logic            byte_ready,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  output logic            q_push,
  output b64e_pkg::job_t  q_job,
  input  logic            q_ready
);

  logic [3:0] residue_bits;
  logic [2:0] residue_count;
  logic [3:0] residue_bits_next;
  logic [2:0] residue_count_next;
  logic [11:0] acc;
  logic [3:0] rem_bits;
  logic [2:0] rem_count;

  assign byte_ready = q_ready;
  assign q_push = byte_valid && q_ready;
  assign acc = {residue_bits, data_byte};

  always_comb begin
    q_job.codes = {b64e_pkg::MAX_CHARS{b64e_pkg::PAD_CHAR}};
    q_job.last = last_byte;
    case (residue_count)
      b64e_pkg::RES_NONE: begin
        q_job.codes[0] = b64e_pkg::encode_sextet(acc[7:2]);
        q_job.last_idx = 2'd0;
        rem_bits = {2'b00, acc[1:0]};
        rem_count = b64e_pkg::RES_TWO;
      end
      b64e_pkg::RES_TWO: begin
        q_job.codes[0] = b64e_pkg::encode_sextet(acc[9:4]);
        q_job.last_idx = 2'd0;
        rem_bits = acc[3:0];
        rem_count = b64e_pkg::RES_FOUR;
      end
      default: begin
        q_job.codes[0] = b64e_pkg::encode_sextet(acc[11:6]);
        q_job.codes[1] = b64e_pkg::encode_sextet(acc[5:0]);
        q_job.last_idx = 2'd1;
        rem_bits = 4'd0;
        rem_count = b64e_pkg::RES_NONE;
      end
    endcase
    if (last_byte) begin
      case (rem_count)
        b64e_pkg::RES_TWO: begin
          q_job.codes[1] = b64e_pkg::encode_sextet({rem_bits[1:0], 4'b0000});
          q_job.last_idx = 2'd3;
        end
        b64e_pkg::RES_FOUR: begin
          q_job.codes[1] = b64e_pkg::encode_sextet({rem_bits, 2'b00});
          q_job.last_idx = 2'd2;
        end
        default: begin
        end
      endcase
      residue_bits_next = 4'd0;
      residue_count_next = b64e_pkg::RES_NONE;
    end else begin
      residue_bits_next = rem_bits;
      residue_count_next = rem_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      residue_bits <= 4'd0;
      residue_count <= b64e_pkg::RES_NONE;
    end else if (q_push) begin
      residue_bits <= residue_bits_next;
      residue_count <= residue_count_next;
    end
  end

endmodule

/* rtl/b64e_queue.sv */
// Short job queue between the front end and the character emitter.
// Depends on b64e_pkg.
module b64e_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64e_pkg::job_t  push_job,
  output logic            push_ready,
  output logic            pop_valid,
  output b64e_pkg::job_t  pop_job,
  input  logic            pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64e_pkg::job_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_job = entries[rd_ptr];
  assign do_push = push && push_ready;
  assign do_pop = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/b64e_back.sv */
// Back end: walks the characters of each queued job into the output register,
// one per cycle unless char_ready stalls it. Depends on b64e_pkg.
module b64e_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  b64e_pkg::job_t                q_job,
  output logic                          q_pop,
  output logic                          char_valid,
  input  logic                          char_ready,
  output logic [b64e_pkg::CHAR_W-1:0]   char_code,
  output logic                          last_char
);

  logic [b64e_pkg::CHAR_IDX_W-1:0] idx;
  logic load;
  logic final_of_job;

  assign load = q_valid && (!char_valid || char_ready);
  assign final_of_job = (idx == q_job.last_idx);
  assign q_pop = load && final_of_job;

  always_ff @(posedge clk) begin
    if (load) begin
      char_code <= q_job.codes[idx];
      last_char <= q_job.last && final_of_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      idx <= '0;
    end else if (load) begin
      char_valid <= 1'b1;
      idx <= final_of_job ? '0 : idx + 1'b1;
    end else if (char_ready) begin
      char_valid <= 1'b0;
    end
  end

endmodule

/* rtl/base64_stream_encoder_core.sv */
// Base64 stream encoder top level: front end, job queue and character emitter.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back and the macro header.
// The first character of a byte passes through a queue entry and the output register.
// Throughput: one character per cycle through the single output register, unless
// char_ready stalls it; a plain byte gives 1 or 2 characters and the last byte 2 to 4.
// Reset clears the leftover bits, the queue and the output valid; no clearing pass.
`include "base64_stream_encoder_core_macros.svh"

module base64_stream_encoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  output logic                          byte_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          last_byte,
  output logic                          char_valid,
  input  logic                          char_ready,
  output logic [b64e_pkg::CHAR_W-1:0]   char_code,
  output logic                          last_char
);

  logic push;
  logic push_ready;
  b64e_pkg::job_t push_job;
  logic q_valid;
  b64e_pkg::job_t q_job;
  logic q_pop;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .q_push     (push),
    .q_job      (push_job),
    .q_ready    (push_ready)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_job    (q_job),
    .pop        (q_pop)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .q_pop      (q_pop),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_code  (char_code),
    .last_char  (last_char)
  );

  `B64E_ALWAYS(a_pop_needs_job, !q_pop || q_valid, "emitter popped an empty queue")
  `B64E_IMPLIES(a_plain_byte_short, push && !push_job.last, push_job.last_idx != 2'd3, "ordinary byte built four characters")
  `B64E_IMPLIES(a_last_byte_long, push && push_job.last, push_job.last_idx != 2'd0, "last byte built a single character")

endmodule
